/* sv/spao_pkg.sv */
`default_nettype none

package spao_pkg;

	// Width of one accumulator slice, held by one cell of the phase chain.
	localparam int unsigned SLICE_W = 8;

	// Reset values of the configuration register and the held quantities.
	localparam logic [31:0] STEP_RESET = 32'd97392;
	localparam logic [15:0] FREQ_RESET = 16'd440;
	localparam logic [15:0] AMP_RESET  = 16'd13107;

	// Peak magnitude of the sine table, Q1.15.
	localparam logic [15:0] FULL_SCALE = 16'd32767;

	// Rounding constant of the amplitude product.
	localparam logic [31:0] PROD_ROUND = 32'd32768;

	// Quarter turn in Q2.30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Divisors of the odd Taylor terms, (2n)(2n+1) for n = 1 to 7.
	localparam longint unsigned TAYLOR_DIV [7] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
	};

	// Quarter-wave entry k of a table with 2^qbits entries:
	// round(32767 * sin(pi/2 * k / 2^qbits)), in integer arithmetic.
	function automatic logic [15:0] quarter_sine(input int unsigned k,
		input int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned scaled;
		longint          sum;
		x = (HALF_PI_Q30 * longint'(k) + ((64'd1 << qbits) >> 1)) >> qbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 0; n < 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n & 1) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		scaled = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		return 16'(scaled);
	endfunction

endpackage

`default_nettype wire

/* sv/spao_cell.sv */
`default_nettype none

// One slice of the carry-pipelined phase accumulator. The cell holds its
// slice of the phase, adds its slice of the increment and the carry of the
// previous cell, and hands the request on with its carry one stage later.
module spao_cell
	import spao_pkg::*;
#(
	parameter int unsigned ACC_W = 32,
	parameter int unsigned K     = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vld_in,
	output logic                  rdy_up,
	input  wire logic [ACC_W-1:0] inc_in,
	input  wire logic [ACC_W-1:0] phase_in,
	input  wire logic             carry_in,
	input  wire logic [15:0]      amp_in,
	output logic                  vld_out,
	input  wire logic             rdy_dn,
	output logic [ACC_W-1:0]      inc_out,
	output logic [ACC_W-1:0]      phase_out,
	output logic                  carry_out,
	output logic [15:0]           amp_out
);

	logic               en;
	logic [SLICE_W-1:0] acc_q;
	logic [SLICE_W:0]   sum;
	logic [ACC_W-1:0]   phase_nx;
	logic               vld_s1;
	logic [ACC_W-1:0]   inc_s1;
	logic [ACC_W-1:0]   phase_s1;
	logic               carry_s1;
	logic [15:0]        amp_s1;

	// The stage moves when it is empty or the next one takes its request.
	assign en     = !vld_s1 || rdy_dn;
	assign rdy_up = en;

	// Slice sum with the carry from the lower slice.
	assign sum = {1'b0, acc_q} + {1'b0, inc_in[K*SLICE_W +: SLICE_W]}
		+ {{SLICE_W{1'b0}}, carry_in};

	// The request leaves with this slice of the phase before the add.
	always_comb begin
		phase_nx = phase_in;
		phase_nx[K*SLICE_W +: SLICE_W] = acc_q;
	end

	// Control state: stage valid and the phase slice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else if (en) begin
			vld_s1 <= vld_in;
			if (vld_in) begin
				acc_q <= sum[SLICE_W-1:0];
			end
		end
	end

	// Payload of the request as it passes this cell.
	always_ff @(posedge clk) begin
		if (en && vld_in) begin
			inc_s1   <= inc_in;
			phase_s1 <= phase_nx;
			carry_s1 <= sum[SLICE_W];
			amp_s1   <= amp_in;
		end
	end

	assign vld_out   = vld_s1;
	assign inc_out   = inc_s1;
	assign phase_out = phase_s1;
	assign carry_out = carry_s1;
	assign amp_out   = amp_s1;

endmodule

`default_nettype wire

/* sv/spao_shaper.sv */
`default_nettype none

// Sine lookup from the folded quarter-wave table and the amplitude product,
// in two pipeline stages.
module spao_shaper
	import spao_pkg::*;
#(
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       vld_in,
	output logic                            rdy_up,
	input  wire logic [TABLE_ADDR_BITS-1:0] addr,
	input  wire logic [15:0]                amp_in,
	output logic                            vld_out,
	input  wire logic                       rdy_dn,
	output logic [15:0]                     sample_out
);

	localparam int unsigned QB    = TABLE_ADDR_BITS - 2;
	localparam int unsigned QSIZE = 1 << QB;

	logic [15:0]   quarter_tab [QSIZE];
	logic [1:0]    quad;
	logic [QB-1:0] j;
	logic [QB-1:0] idx;
	logic [15:0]   mag_lut;
	logic          en_a;
	logic          en_b;
	logic          vld_s1;
	logic [15:0]   mag_s1;
	logic          neg_s1;
	logic [15:0]   amp_s1;
	logic [31:0]   prod;
	logic          vld_s2;
	logic [15:0]   mag_s2;
	logic          neg_s2;

	// Constant quarter-wave table.
	for (genvar k = 0; k < QSIZE; k++) begin : g_tab
		localparam logic [15:0] ENTRY = quarter_sine(k, QB);
		assign quarter_tab[k] = ENTRY;
	end

	// Fold the address: odd quadrants read the table backwards, and the
	// crest of the wave, which lies past the table's end, is full scale.
	assign quad = addr[TABLE_ADDR_BITS-1 -: 2];
	assign j    = addr[QB-1:0];
	assign idx  = quad[0] ? ({QB{1'b0}} - j) : j;

	always_comb begin
		if (quad[0] && (j == '0)) begin
			mag_lut = FULL_SCALE;
		end else begin
			mag_lut = quarter_tab[idx];
		end
	end

	// Rounded product of the amplitude and the sine magnitude.
	assign prod = {16'd0, amp_s1} * {16'd0, mag_s1} + PROD_ROUND;

	assign en_b   = !vld_s2 || rdy_dn;
	assign en_a   = !vld_s1 || en_b;
	assign rdy_up = en_a;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_a) begin
				vld_s1 <= vld_in;
			end
			if (en_b) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Lookup and product stages.
	always_ff @(posedge clk) begin
		if (en_a && vld_in) begin
			mag_s1 <= mag_lut;
			neg_s1 <= quad[1];
			amp_s1 <= amp_in;
		end
		if (en_b && vld_s1) begin
			mag_s2 <= prod[31:16];
			neg_s2 <= neg_s1;
		end
	end

	// The sign of the sine goes back on the scaled magnitude.
	assign vld_out    = vld_s2;
	assign sample_out = neg_s2 ? (16'd0 - mag_s2) : mag_s2;

endmodule

`default_nettype wire

/* sv/spao_out_buf.sv */
`default_nettype none

// Output register with a skid entry. The ready toward the pipeline is a
// register, so a stall on the sample side reaches the pipeline only through
// that register, and the skid entry catches the request already on its way.
module spao_out_buf (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        vld_in,
	output logic             rdy_up,
	input  wire logic [15:0] data_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      out_data
);

	logic        main_vld_q;
	logic [15:0] main_data_q;
	logic        skid_vld_q;
	logic [15:0] skid_data_q;
	logic        take;
	logic        load;

	assign rdy_up = !skid_vld_q;
	assign take   = main_vld_q && !out_stall;
	assign load   = !skid_vld_q && vld_in;

	// Valid bits of the two entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!main_vld_q || take) begin
			main_vld_q <= vld_in;
		end else if (vld_in) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Data of the two entries.
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				main_data_q <= skid_data_q;
			end
		end else if (load) begin
			if (!main_vld_q || take) begin
				main_data_q <= data_in;
			end else begin
				skid_data_q <= data_in;
			end
		end
	end

	assign out_valid = main_vld_q;
	assign out_data  = main_data_q;

endmodule

`default_nettype wire

/* sv/sine_phase_accumulator_oscillator_unit.sv */
`default_nettype none

// Sine oscillator with a phase accumulator and a quarter-wave sine table.
// Each request on the req channel (req_valid, req_stall, freq_hz, amplitude)
// asks for one sample; a nonzero freq_hz or amplitude replaces the held
// value first, a zero keeps it. The sample channel (sample_valid,
// sample_stall, sample) returns held amplitude times the sine of the phase,
// after which the phase advances by held frequency times step_per_hz.
// A request moves when valid is high and stall is low on its channel.
// step_per_hz is written on the cfg channel (cfg_valid, cfg_ready, cfg_data);
// the user must write it only while no request is in flight, and the block
// itself does not enforce this; cfg_ready is always high. Throughput is one
// sample per cycle while sample_stall is low. From acceptance to sample_valid
// a request passes one stage for the increment product, one cell per 8-bit
// accumulator slice, the table lookup, the amplitude product, then the output
// register. Reset clears the phase to zero, holds 440 Hz and amplitude 13107,
// and sets step_per_hz to 97392. A stalled sample holds; the pipeline keeps
// accepting until it has filled behind it, then raises req_stall.
module sine_phase_accumulator_oscillator_unit
	import spao_pkg::*;
#(
	parameter int unsigned PHASE_BITS      = 32,
	parameter int unsigned TABLE_ADDR_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [15:0] freq_hz,
	input  wire logic [15:0] amplitude,
	output logic             sample_valid,
	input  wire logic        sample_stall,
	output logic signed [15:0] sample,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned NC    = (PHASE_BITS + SLICE_W - 1) / SLICE_W;
	localparam int unsigned ACC_W = NC * SLICE_W;

	logic [31:0]      step_q;
	logic [15:0]      held_freq_q;
	logic [15:0]      held_amp_q;
	logic [15:0]      f_sel;
	logic [15:0]      a_sel;
	logic [47:0]      prod;
	logic             en_s1;
	logic             vld_s1;
	logic [ACC_W-1:0] inc_s1;
	logic [15:0]      amp_s1;

	logic [NC:0]      ch_vld;
	logic [NC:0]      ch_rdy;
	logic [NC:0]      ch_carry;
	logic [ACC_W-1:0] ch_inc   [NC+1];
	logic [ACC_W-1:0] ch_phase [NC+1];
	logic [15:0]      ch_amp   [NC+1];

	logic             sh_vld;
	logic             sh_rdy;
	logic             sh_rdy_dn;
	logic [15:0]      sh_sample;
	logic [15:0]      out_data;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	// Field update: zero keeps the held value.
	assign f_sel = (freq_hz != 16'd0) ? freq_hz : held_freq_q;
	assign a_sel = (amplitude != 16'd0) ? amplitude : held_amp_q;
	assign prod  = {32'd0, f_sel} * {16'd0, step_q};

	assign en_s1     = !vld_s1 || ch_rdy[0];
	assign req_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_freq_q <= FREQ_RESET;
			held_amp_q  <= AMP_RESET;
			vld_s1      <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= req_valid;
			if (req_valid) begin
				held_freq_q <= f_sel;
				held_amp_q  <= a_sel;
			end
		end
	end

	// Increment stage: the product reduced to the phase width.
	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			inc_s1 <= ACC_W'(prod[PHASE_BITS-1:0]);
			amp_s1 <= a_sel;
		end
	end

	// Chain of accumulator cells, lowest slice first.
	assign ch_vld[0]   = vld_s1;
	assign ch_inc[0]   = inc_s1;
	assign ch_phase[0] = '0;
	assign ch_carry[0] = 1'b0;
	assign ch_amp[0]   = amp_s1;
	assign ch_rdy[NC]  = sh_rdy;

	for (genvar k = 0; k < NC; k++) begin : g_cell
		spao_cell #(
			.ACC_W (ACC_W),
			.K     (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.vld_in    (ch_vld[k]),
			.rdy_up    (ch_rdy[k]),
			.inc_in    (ch_inc[k]),
			.phase_in  (ch_phase[k]),
			.carry_in  (ch_carry[k]),
			.amp_in    (ch_amp[k]),
			.vld_out   (ch_vld[k+1]),
			.rdy_dn    (ch_rdy[k+1]),
			.inc_out   (ch_inc[k+1]),
			.phase_out (ch_phase[k+1]),
			.carry_out (ch_carry[k+1]),
			.amp_out   (ch_amp[k+1])
		);
	end

	// Sine lookup and amplitude scaling on the top bits of the phase.
	spao_shaper #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_shaper (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_in     (ch_vld[NC]),
		.rdy_up     (sh_rdy),
		.addr       (ch_phase[NC][PHASE_BITS-1 -: TABLE_ADDR_BITS]),
		.amp_in     (ch_amp[NC]),
		.vld_out    (sh_vld),
		.rdy_dn     (sh_rdy_dn),
		.sample_out (sh_sample)
	);

	// Output register and skid entry.
	spao_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_in    (sh_vld),
		.rdy_up    (sh_rdy_dn),
		.data_in   (sh_sample),
		.out_valid (sample_valid),
		.out_stall (sample_stall),
		.out_data  (out_data)
	);

	assign sample = signed'(out_data);

endmodule

`default_nettype wire

/* tb/sine_phase_accumulator_oscillator_unit_tb.sv */
`timescale 1ns / 100ps

module sine_phase_accumulator_oscillator_unit_tb;
	import spao_pkg::*;

	localparam int unsigned QUARTER_ENTRIES = 256;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES     = 300;
	localparam int unsigned DRAIN_CYCLES    = 20;
	localparam int unsigned PHASE_ITEMS     = 120;
	localparam int unsigned RANDOM_PHASES   = 5;
	localparam int unsigned PRESSURE_PHASE  = 4;

	// One table address per hertz: the low 22 phase bits never change.
	localparam logic [31:0] STEP_ONE_ADDR = 32'h0040_0000;

	localparam logic signed [15:0] PEAK_POS = 16'sd32767;
	localparam logic signed [15:0] PEAK_NEG = -16'sd32767;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_CFG,
		ROW_SEEK
	} row_kind_t;

	// A directed row. For ROW_CFG, word is the step value; for ROW_SEEK, it is
	// the table address that the next request must sample.
	typedef struct packed {
		row_kind_t          kind;
		logic [31:0]        word;
		logic [15:0]        freq;
		logic [15:0]        amp;
		logic               pin;
		logic signed [15:0] want;
	} stim_row_t;

	localparam int unsigned DIRECTED_ROWS = 29;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Phase is zero after reset, so the first sample is zero.
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b1, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'hFFFF, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0001, 16'h0001, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h8000, 16'h8000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h7FFF, 16'h7FFF, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h5555, 16'hAAAA, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'hAAAA, 16'h5555, 1'b0, 16'sd0},
		// Largest step with the largest frequency overflows the phase add.
		'{ROW_CFG,  32'hFFFF_FFFF, 16'h0000, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0002, 16'h0000, 1'b0, 16'sd0},
		'{ROW_CFG,  32'd1, 16'h0000, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0001, 16'h00FF, 1'b0, 16'sd0},
		// A zero step freezes the phase.
		'{ROW_CFG,  32'd0, 16'h0000, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h1234, 16'hFFFF, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h1234, 16'hFFFF, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h1234, 16'hFFFF, 1'b0, 16'sd0},
		// Walk the quadrant boundaries, where the folded lookup needs full scale.
		'{ROW_CFG,  STEP_ONE_ADDR, 16'h0000, 16'h0000, 1'b0, 16'sd0},
		'{ROW_SEEK, 32'd256, 16'h0000, 16'hFFFF, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'd512, 16'h0000, 1'b1, PEAK_POS},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b1, PEAK_NEG},
		'{ROW_ITEM, 32'd0, 16'd256, 16'h0000, 1'b1, PEAK_POS},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b1, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b1, PEAK_NEG},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b1, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'h0000, 16'h0000, 1'b0, 16'sd0},
		'{ROW_ITEM, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0, 16'sd0}
	};

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [15:0]        freq_hz;
	logic [15:0]        amplitude;
	logic               sample_valid;
	logic               sample_stall = 1'b0;
	logic signed [15:0] sample;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [31:0]        cfg_data;

	// Hand-typed expectation that travels with the request it belongs to.
	logic               pinned_on;
	logic signed [15:0] pinned_value;

	// Oscillator state as the predictor sees it.
	logic [31:0] osc_phase;
	logic [15:0] osc_freq;
	logic [15:0] osc_amp;
	logic [31:0] osc_step;
	logic [15:0] quarter_sine_lut [QUARTER_ENTRIES];

	logic signed [15:0] expected_samples [$];
	int unsigned        mismatch_count = 0;
	int unsigned        quiet_cycles = 0;

	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct = 0;
	bit          hold_armed = 1'b0;
	int unsigned hold_count = 0;

	sine_phase_accumulator_oscillator_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.freq_hz     (freq_hz),
		.amplitude   (amplitude),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Quarter-wave entry k: odd Taylor series of sin in Q2.30, scaled to Q1.15.
	function automatic logic [15:0] sine_entry(input int unsigned k);
		longint unsigned angle;
		longint unsigned angle_sq;
		longint unsigned term;
		longint          acc;
		longint unsigned scaled;
		angle = (64'd1686629713 * k + 64'd128) >> 8;
		angle_sq = (angle * angle) >> 30;
		term = angle;
		acc = longint'(angle);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * angle_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (64'sd1 <<< 30)) begin
			acc = 64'sd1 <<< 30;
		end
		scaled = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
		return scaled[15:0];
	endfunction

	// Forms the sample for one request, then advances the phase.
	function automatic logic signed [15:0] next_sample(input logic [15:0] f,
		input logic [15:0] a);
		logic [9:0]         addr;
		logic [15:0]        sine_mag;
		logic [31:0]        product;
		logic signed [15:0] mag;
		if (f != 16'd0) begin
			osc_freq = f;
		end
		if (a != 16'd0) begin
			osc_amp = a;
		end
		addr = osc_phase[31:22];
		if (addr[8]) begin
			sine_mag = (addr[7:0] == 8'd0) ? FULL_SCALE :
				quarter_sine_lut[8'd0 - addr[7:0]];
		end else begin
			sine_mag = quarter_sine_lut[addr[7:0]];
		end
		product = {16'd0, osc_amp} * {16'd0, sine_mag} + PROD_ROUND;
		mag = product[31:16];
		osc_phase = osc_phase + {16'd0, osc_freq} * osc_step;
		return addr[9] ? -mag : mag;
	endfunction

	// Track register writes and predict each accepted request.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (cfg_valid && cfg_ready) begin
			osc_step = cfg_data;
		end
		if (req_valid && !req_stall) begin
			want = next_sample(freq_hz, amplitude);
			if (pinned_on) begin
				want = pinned_value;
			end
			expected_samples.push_back(want);
		end
	end

	// Compare each accepted sample with the oldest expectation.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (sample_valid && !sample_stall) begin
			if (expected_samples.size() == 0) begin
				$error("sample: expected none, actual %0d", sample);
				mismatch_count++;
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want) begin
					$error("sample: expected %0d, actual %0d", want, sample);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver stalls at random; once armed, it holds off for a long stretch first.
	always @(posedge clk) begin
		if (hold_armed && hold_count < HOLD_CYCLES) begin
			sample_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			sample_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// End the run when nothing has moved for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (sample_valid && !sample_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one request after a random gap and waits until it is accepted.
	task automatic send_request(input logic [15:0] f, input logic [15:0] a,
		input logic pin, input logic signed [15:0] pin_value);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		freq_hz <= f;
		amplitude <= a;
		pinned_on <= pin;
		pinned_value <= pin_value;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected sample has arrived. The
	// first edge lets the prediction of the last accepted request land.
	task automatic drain_samples();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_step(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] phase_steps [RANDOM_PHASES];
		int unsigned idle_table [RANDOM_PHASES];
		int unsigned stall_table [RANDOM_PHASES];
		logic [9:0]  addr_gap;
		logic [15:0] f;
		logic [15:0] a;

		for (int k = 0; k < QUARTER_ENTRIES; k++) begin
			quarter_sine_lut[k] = sine_entry(k);
		end
		osc_phase = 32'd0;
		osc_freq = FREQ_RESET;
		osc_amp = AMP_RESET;
		osc_step = STEP_RESET;

		arst_n = 1'b0;
		req_valid = 1'b0;
		freq_hz = 16'd0;
		amplitude = 16'd0;
		cfg_valid = 1'b0;
		cfg_data = 32'd0;
		pinned_on = 1'b0;
		pinned_value = 16'sd0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; a register write only happens with the pipeline empty.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			case (DIRECTED[i].kind)
				ROW_CFG: begin
					drain_samples();
					write_step(DIRECTED[i].word);
				end
				ROW_SEEK: begin
					// The phase is settled here, since a write always drains first.
					addr_gap = DIRECTED[i].word[9:0] - osc_phase[31:22];
					send_request((addr_gap == 10'd0) ? 16'd1024 : {6'd0, addr_gap},
						DIRECTED[i].amp, 1'b0, 16'sd0);
				end
				default: begin
					send_request(DIRECTED[i].freq, DIRECTED[i].amp, DIRECTED[i].pin,
						DIRECTED[i].want);
				end
			endcase
		end

		// Random phases, each under its own step and idling pattern.
		phase_steps = '{$urandom | 32'd1, STEP_RESET, $urandom_range(2000000, 50000),
			32'hFFFF_FFFF, $urandom | 32'd1};
		idle_table = '{0, 72, 0, 36, 0};
		stall_table = '{0, 0, 72, 36, 20};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_samples();
			write_step(phase_steps[p]);
			sender_idle_pct = idle_table[p];
			stall_pct = stall_table[p];
			hold_armed = (p == PRESSURE_PHASE);
			repeat (PHASE_ITEMS) begin
				case ($urandom_range(9))
					0, 1, 2: f = 16'd0;
					3, 4, 5, 6: f = 16'($urandom_range(4000, 1));
					default: f = 16'($urandom_range(65535));
				endcase
				a = ($urandom_range(9) < 3) ? 16'd0 : 16'($urandom_range(65535));
				send_request(f, a, 1'b0, 16'sd0);
			end
		end

		drain_samples();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sine_phase_accumulator_oscillator_unit.f */
sv/spao_pkg.sv
sv/spao_cell.sv
sv/spao_shaper.sv
sv/spao_out_buf.sv
sv/sine_phase_accumulator_oscillator_unit.sv
tb/sine_phase_accumulator_oscillator_unit_tb.sv
